/* rtl/bld_pkg.sv */
package bld_pkg;

    typedef enum logic [3:0] {
        OP_ADD_FRONT = 4'd0,
        OP_ADD_BACK  = 4'd1,
        OP_DEL_FRONT = 4'd2,
        OP_DEL_BACK  = 4'd3,
        OP_CLEAR     = 4'd4,
        OP_DEL_VALUE = 4'd5,
        OP_READ_ALL  = 4'd6,
        OP_READ_HEAD = 4'd7,
        OP_READ_TAIL = 4'd8
    } opcode_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // queued command between front and back
    typedef struct packed {
        opcode_t     op;
        logic [31:0] value;
        logic [4:0]  count;
    } cmd_t;

    // result item, tdata layout: value_res, has_value, status; tlast separate
    typedef struct packed {
        logic [1:0]  status;
        logic        has_value;
        logic [31:0] value_res;
    } res_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_COMPACT,
        BK_STATUS
    } bk_state_t;

endpackage

/* rtl/bld_front.sv */
module bld_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             item_valid,
    output logic             item_ready,
    input  logic [3:0]       item_opcode,
    input  logic [31:0]      item_value,
    input  logic [4:0]       item_count,
    output logic             cmd_valid,
    input  logic             cmd_ready,
    output bld_pkg::cmd_t    cmd
);
    import bld_pkg::*;

    localparam int QD = 2;

    cmd_t       buf_reg [QD];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       known;
    logic       push, pop;

    // drop codes that mean nothing: they have no result and no effect
    assign known      = (item_opcode <= OP_READ_TAIL);
    assign item_ready = (cnt_reg != 2'(QD));
    assign push       = item_valid && item_ready && known;
    assign pop        = cmd_valid && cmd_ready;
    assign cmd_valid  = (cnt_reg != 2'd0);
    assign cmd        = buf_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    // hold queued commands
    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wp_reg] <= '{op: opcode_t'(item_opcode), value: item_value,
                                 count: item_count};
    end

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(QD)) else $error("queue overflow");
    a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd0) |-> !pop) else $error("pop from empty queue");
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> (cnt_reg == $past(cnt_reg) + 2'd1)) else $error("count slip");
`endif
endmodule

/* rtl/bld_back.sv */
module bld_back #(
    parameter int DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  bld_pkg::cmd_t    cmd,
    output logic             res_valid,
    input  logic             res_ready,
    output bld_pkg::res_t    res_data,
    output logic             res_last
);
    import bld_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

    logic [31:0] mem [DEPTH];

    bk_state_t     st_reg, st_next;
    logic [AW-1:0] head_reg, head_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] i_reg, i_next;     // walk position
    logic [CW-1:0] n_reg, n_next;     // read length or compact source limit
    logic [CW-1:0] w_reg, w_next;     // compact write position
    logic [CW-1:0] s_reg, s_next;     // read start offset
    logic [31:0]   key_reg, key_next;

    res_t          ob_res_reg, ob_res_next;
    logic          ob_last_reg, ob_last_next;
    logic          ob_v_reg, ob_v_next;

    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [31:0]   mem_wd;
    logic [AW-1:0] rd_slot;
    logic [31:0]   rd_data_reg;
    logic          ob_free;
    logic [CW-1:0] k_sat;

    function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] p);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(p);
        if (s >= (CW+1)'(DEPTH))
            s = s - (CW+1)'(DEPTH);
        return s[AW-1:0];
    endfunction

    assign ob_free   = !ob_v_reg || res_ready;
    assign res_valid = ob_v_reg;
    assign res_data  = ob_res_reg;
    assign res_last  = ob_last_reg;
    assign cmd_ready = (st_reg == BK_IDLE) && ob_free;
    // fetch the entry the walk looks at next cycle
    assign rd_slot   = slot(head_reg, s_next + i_next);
    assign k_sat     = (32'(cmd.count) < 32'(cnt_reg)) ? CW'(cmd.count) : cnt_reg;

    always_comb
    begin
        st_next      = st_reg;
        head_next    = head_reg;
        cnt_next     = cnt_reg;
        i_next       = i_reg;
        n_next       = n_reg;
        w_next       = w_reg;
        s_next       = s_reg;
        key_next     = key_reg;
        ob_v_next    = ob_v_reg && !res_ready;
        ob_res_next  = ob_res_reg;
        ob_last_next = ob_last_reg;
        mem_we       = 1'b0;
        mem_wa       = '0;
        mem_wd       = cmd.value;
        case (st_reg)
            BK_IDLE:
            begin
                if (cmd_valid && ob_free)
                begin
                    ob_v_next    = 1'b1;
                    ob_last_next = 1'b1;
                    ob_res_next  = '{status: ST_OK, has_value: 1'b0, value_res: '0};
                    i_next       = '0;
                    s_next       = '0;
                    case (cmd.op)
                        OP_ADD_FRONT:
                        begin
                            if (cnt_reg >= DEPTH_C)
                                ob_res_next.status = ST_FULL;
                            else
                            begin
                                head_next = slot(head_reg, CW'(DEPTH - 1));
                                mem_we    = 1'b1;
                                mem_wa    = slot(head_reg, CW'(DEPTH - 1));
                                cnt_next  = cnt_reg + 1'b1;
                            end
                        end
                        OP_ADD_BACK:
                        begin
                            if (cnt_reg >= DEPTH_C)
                                ob_res_next.status = ST_FULL;
                            else
                            begin
                                mem_we   = 1'b1;
                                mem_wa   = slot(head_reg, cnt_reg);
                                cnt_next = cnt_reg + 1'b1;
                            end
                        end
                        OP_DEL_FRONT:
                        begin
                            if (cnt_reg == '0)
                                ob_res_next.status = ST_EMPTY;
                            else
                            begin
                                head_next = slot(head_reg, CW'(1));
                                cnt_next  = cnt_reg - 1'b1;
                            end
                        end
                        OP_DEL_BACK:
                        begin
                            if (cnt_reg == '0)
                                ob_res_next.status = ST_EMPTY;
                            else
                                cnt_next = cnt_reg - 1'b1;
                        end
                        OP_CLEAR:
                        begin
                            head_next = '0;
                            cnt_next  = '0;
                        end
                        OP_DEL_VALUE:
                        begin
                            if (cnt_reg == '0)
                                ob_res_next.status = ST_EMPTY;
                            else
                            begin
                                // walk and compact, status goes out at the end
                                ob_v_next = 1'b0;
                                key_next  = cmd.value;
                                n_next    = cnt_reg;
                                w_next    = '0;
                                st_next   = BK_COMPACT;
                            end
                        end
                        default:
                        begin
                            // read-outs
                            if (cmd.op == OP_READ_ALL)
                                n_next = cnt_reg;
                            else
                                n_next = k_sat;
                            if (cmd.op == OP_READ_TAIL)
                                s_next = cnt_reg - k_sat;
                            if (((cmd.op == OP_READ_ALL) ? cnt_reg : k_sat) == '0)
                                ob_res_next.status = ST_EMPTY;
                            else
                            begin
                                ob_v_next = 1'b0;
                                st_next   = BK_READ;
                            end
                        end
                    endcase
                end
            end
            BK_READ:
            begin
                // emit one entry per free output slot
                if (ob_free)
                begin
                    ob_v_next    = 1'b1;
                    ob_res_next  = '{status: ST_OK, has_value: 1'b1, value_res: rd_data_reg};
                    ob_last_next = (i_reg + 1'b1 == n_reg);
                    i_next       = i_reg + 1'b1;
                    if (i_reg + 1'b1 == n_reg)
                        st_next = BK_IDLE;
                end
            end
            BK_COMPACT:
            begin
                // move each kept entry down to the write position
                if (rd_data_reg != key_reg)
                begin
                    mem_we = 1'b1;
                    mem_wa = slot(head_reg, w_reg);
                    mem_wd = rd_data_reg;
                    w_next = w_reg + 1'b1;
                end
                i_next = i_reg + 1'b1;
                if (i_reg + 1'b1 == n_reg)
                begin
                    cnt_next = (rd_data_reg != key_reg) ? w_reg + 1'b1 : w_reg;
                    st_next  = BK_STATUS;
                end
            end
            BK_STATUS:
            begin
                if (ob_free)
                begin
                    ob_v_next    = 1'b1;
                    ob_last_next = 1'b1;
                    ob_res_next  = '{status: ST_OK, has_value: 1'b0, value_res: '0};
                    st_next      = BK_IDLE;
                end
            end
            default: st_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= BK_IDLE;
            head_reg <= '0;
            cnt_reg  <= '0;
            ob_v_reg <= 1'b0;
            i_reg    <= '0;
            s_reg    <= '0;
        end
        else
        begin
            st_reg   <= st_next;
            head_reg <= head_next;
            cnt_reg  <= cnt_next;
            ob_v_reg <= ob_v_next;
            i_reg    <= i_next;
            s_reg    <= s_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        w_reg       <= w_next;
        key_reg     <= key_next;
        ob_res_reg  <= ob_res_next;
        ob_last_reg <= ob_last_next;
    end

    // write the store and register one read a cycle
    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_wa] <= mem_wd;
        rd_data_reg <= mem[rd_slot];
    end

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= DEPTH_C) else $error("entry count beyond depth");
    a_idle_take: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_ready) |-> (st_reg == BK_IDLE)) else $error("command taken while busy");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (ob_v_reg && !res_ready) |=> (ob_v_reg && $stable(ob_res_reg))) else $error("result lost");
`endif
endmodule

/* rtl/bounded_list_deque_engine_core.sv */
// channel | dir | tdata (low bit up)                      | tuser | tlast
// s_axis  | in  | opcode[3:0] value[35:4] count[40:36]     | -     | -
// m_axis  | out | value_res[31:0] has_value[32] status[34:33]| -   | last
// A simple command's result is registered as the engine takes it from the queue;
// the engine takes one simple command per cycle while m_axis is ready.
// Delete-by-value walks and compacts every entry before its status goes out;
// a read-out gives one entry per cycle while m_axis is ready.
// A two-entry queue parts the input side from the list engine.
// rst_n clears head, count and the queue; the store is not cleared.
// A stalled m_axis holds the engine; s_axis keeps filling the queue.
module bounded_list_deque_engine_core #(
    parameter int DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // opcode, value, count, zero fill
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [39:0] m_axis_tdata,   // value_res, has_value, status, zero fill
    output logic        m_axis_tlast
);
    import bld_pkg::*;

    logic cmd_valid, cmd_ready;
    cmd_t cmd;
    res_t res;

    bld_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (s_axis_tvalid),
        .item_ready  (s_axis_tready),
        .item_opcode (s_axis_tdata[3:0]),
        .item_value  (s_axis_tdata[35:4]),
        .item_count  (s_axis_tdata[40:36]),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd)
    );

    bld_back #(.DEPTH(DEPTH)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .res_valid (m_axis_tvalid),
        .res_ready (m_axis_tready),
        .res_data  (res),
        .res_last  (m_axis_tlast)
    );

    assign m_axis_tdata = {5'd0, res};
endmodule

/* tb/tb_bounded_list_deque_engine_core.sv */
`timescale 1ns / 1ps

module tb_bounded_list_deque_engine_core;
    import bld_pkg::*;

    localparam int DEPTH = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic [3:0]  op;
        logic [31:0] value;
        logic [4:0]  count;
    } cmd_item_t;

    typedef struct packed {
        logic [31:0] value_res;
        logic        has_value;
        logic [1:0]  status;
        logic        last;
    } list_res_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [47:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        m_axis_tlast;

    bounded_list_deque_engine_core #(.DEPTH(DEPTH)) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    // shadow copy of the list
    logic [31:0] shadow_store [DEPTH];
    int unsigned shadow_head;
    int unsigned shadow_count;

    cmd_item_t   pending_cmds [$];
    list_res_t   expected_results [$];
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;
    bit          all_sent;
    int          error_count;
    int          quiet_cycles;

    // push a status result
    function automatic void push_status(logic [1:0] st);
        list_res_t r;
        r = '{value_res: 32'd0, has_value: 1'b0, status: st, last: 1'b1};
        expected_results.push_back(r);
    endfunction

    // push n entries starting at list position start
    function automatic void push_entries(int unsigned start, int unsigned n);
        list_res_t r;
        if (n == 0)
        begin
            push_status(ST_EMPTY);
            return;
        end
        for (int unsigned i = 0; i < n; i++)
        begin
            r.value_res = shadow_store[(shadow_head + start + i) % DEPTH];
            r.has_value = 1'b1;
            r.status    = ST_OK;
            r.last      = (i + 1 == n);
            expected_results.push_back(r);
        end
    endfunction

    // apply one command to the shadow list and queue its results
    function automatic void apply_cmd(cmd_item_t c);
        int unsigned kept;
        int unsigned n;
        logic [31:0] e;
        n = (c.count < shadow_count) ? c.count : shadow_count;
        case (c.op)
            OP_ADD_FRONT, OP_ADD_BACK:
            begin
                if (shadow_count >= DEPTH)
                    push_status(ST_FULL);
                else
                begin
                    if (c.op == OP_ADD_FRONT)
                    begin
                        shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                        shadow_store[shadow_head] = c.value;
                    end
                    else
                        shadow_store[(shadow_head + shadow_count) % DEPTH] = c.value;
                    shadow_count++;
                    push_status(ST_OK);
                end
            end
            OP_DEL_FRONT, OP_DEL_BACK:
            begin
                if (shadow_count == 0)
                    push_status(ST_EMPTY);
                else
                begin
                    if (c.op == OP_DEL_FRONT)
                        shadow_head = (shadow_head + 1) % DEPTH;
                    shadow_count--;
                    push_status(ST_OK);
                end
            end
            OP_CLEAR:
            begin
                shadow_head = 0;
                shadow_count = 0;
                push_status(ST_OK);
            end
            OP_DEL_VALUE:
            begin
                if (shadow_count == 0)
                    push_status(ST_EMPTY);
                else
                begin
                    kept = 0;
                    for (int unsigned i = 0; i < shadow_count; i++)
                    begin
                        e = shadow_store[(shadow_head + i) % DEPTH];
                        if (e != c.value)
                        begin
                            shadow_store[(shadow_head + kept) % DEPTH] = e;
                            kept++;
                        end
                    end
                    shadow_count = kept;
                    push_status(ST_OK);
                end
            end
            OP_READ_ALL:  push_entries(0, shadow_count);
            OP_READ_HEAD: push_entries(0, n);
            OP_READ_TAIL: push_entries(shadow_count - n, n);
            default: ;
        endcase
    endfunction

    function automatic cmd_item_t make_cmd(logic [3:0] op, logic [31:0] v, logic [4:0] k);
        cmd_item_t c;
        c.op = op;
        c.value = v;
        c.count = k;
        return c;
    endfunction

    // values from a small pool so that delete-by-value finds matches
    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'($urandom_range(0, 3));
            default: return 32'($urandom);
        endcase
    endfunction

    function automatic cmd_item_t random_cmd();
        int unsigned sel;
        sel = $urandom_range(0, 99);
        if (sel < 30)
            return make_cmd(OP_ADD_BACK, pick_value(), 5'($urandom));
        else if (sel < 50)
            return make_cmd(OP_ADD_FRONT, pick_value(), 5'($urandom));
        else if (sel < 96)
            return make_cmd(4'($urandom_range(2, 8)), pick_value(),
                            5'($urandom_range(0, 17)));
        else
            return make_cmd(4'($urandom_range(9, 15)), 32'($urandom), 5'($urandom));
    endfunction

    // clock
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // driver: offer the head of the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
        end
        else
        begin
            automatic logic busy;
            automatic cmd_item_t c;
            busy = s_axis_tvalid && !s_axis_tready;
            if (s_axis_tvalid && s_axis_tready)
                void'(pending_cmds.pop_front());
            if (!busy)
            begin
                if (pending_cmds.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    c = pending_cmds[0];
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {7'd0, c.count, c.value, c.op};
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
            if (s_axis_tvalid && s_axis_tready)
                apply_cmd(cmd_item_t'({s_axis_tdata[3:0], s_axis_tdata[35:4],
                                       s_axis_tdata[40:36]}));
        end
    end

    // receiver stall and long hold-off
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_off_cycles > 0)
        begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor: compare each result with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            automatic list_res_t want;
            if (expected_results.size() == 0)
            begin
                $error("unexpected result tdata=%h tlast=%b", m_axis_tdata, m_axis_tlast);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (m_axis_tdata[31:0] !== want.value_res)
                begin
                    $error("value_res: expected %h, got %h", want.value_res,
                           m_axis_tdata[31:0]);
                    error_count++;
                end
                if (m_axis_tdata[32] !== want.has_value)
                begin
                    $error("has_value: expected %b, got %b", want.has_value, m_axis_tdata[32]);
                    error_count++;
                end
                if (m_axis_tdata[34:33] !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, m_axis_tdata[34:33]);
                    error_count++;
                end
                if (m_axis_tlast !== want.last)
                begin
                    $error("last: expected %b, got %b", want.last, m_axis_tlast);
                    error_count++;
                end
            end
        end
    end

    // watchdog on cycles with no accepted item
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pending_cmds.size() > 0 || s_axis_tvalid || expected_results.size() > 0)
            @(posedge clk);
    endtask

    task automatic run_random(int n, int idle, int stall);
        send_idle_pct = idle;
        recv_stall_pct = stall;
        repeat (n)
            pending_cmds.push_back(random_cmd());
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off_cycles = 0;
        error_count = 0;
        quiet_cycles = 0;
        all_sent = 1'b0;
        shadow_head = 0;
        shadow_count = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed: empty cases, extremes, fill to full, every read form
        pending_cmds.push_back(make_cmd(OP_DEL_FRONT, 32'd0, 5'd0));
        pending_cmds.push_back(make_cmd(OP_DEL_BACK, 32'd0, 5'd0));
        pending_cmds.push_back(make_cmd(OP_DEL_VALUE, 32'd0, 5'd0));
        pending_cmds.push_back(make_cmd(OP_READ_ALL, 32'd0, 5'd0));
        pending_cmds.push_back(make_cmd(OP_ADD_BACK, 32'h7FFF_FFFF, 5'h1F));
        pending_cmds.push_back(make_cmd(OP_DEL_BACK, 32'hFFFF_FFFF, 5'h1F));
        pending_cmds.push_back(make_cmd(OP_ADD_FRONT, 32'h8000_0000, 5'd0));
        for (int i = 0; i < 8; i++)
            pending_cmds.push_back(make_cmd(OP_ADD_BACK, 32'(i % 3), 5'd0));
        for (int i = 0; i < 8; i++)
            pending_cmds.push_back(make_cmd(OP_ADD_FRONT, 32'h5A5A_0000 + 32'(i), 5'd0));
        pending_cmds.push_back(make_cmd(OP_READ_HEAD, 32'd0, 5'd0));
        pending_cmds.push_back(make_cmd(OP_READ_HEAD, 32'd0, 5'd3));
        pending_cmds.push_back(make_cmd(OP_READ_TAIL, 32'd0, 5'd16));
        pending_cmds.push_back(make_cmd(OP_READ_TAIL, 32'd0, 5'd31));
        pending_cmds.push_back(make_cmd(4'd15, 32'hFFFF_FFFF, 5'h1F));
        pending_cmds.push_back(make_cmd(OP_DEL_VALUE, 32'd1, 5'd0));
        pending_cmds.push_back(make_cmd(OP_DEL_VALUE, 32'd1234, 5'd0));
        pending_cmds.push_back(make_cmd(OP_READ_ALL, 32'd0, 5'd0));
        wait_drained();

        // long receiver hold-off while commands keep coming
        hold_off_cycles = 300;
        run_random(15, 0, 0);
        run_random(15, 0, 0);
        run_random(15, 52, 0);
        run_random(15, 0, 52);
        run_random(15, 31, 31);
        pending_cmds.push_back(make_cmd(OP_CLEAR, 32'd0, 5'd0));
        pending_cmds.push_back(make_cmd(OP_READ_ALL, 32'd0, 5'd0));
        wait_drained();

        repeat (50) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

/* files.f */
rtl/bld_pkg.sv
rtl/bld_front.sv
rtl/bld_back.sv
rtl/bounded_list_deque_engine_core.sv
tb/tb_bounded_list_deque_engine_core.sv
